// ===== sv/dbl_pkg.sv =====
// Shared types, constants and the decibel lookup ROM for the decibel log10 block.
// No dependencies; the conversion module, the top level and the checker import it.
package dbl_pkg;

  localparam int unsigned PowerWidth   = 64;
  localparam int unsigned MsbWidth     = 6;
  localparam int unsigned ShiftWidth   = 6;
  localparam int unsigned MantBits     = 8;
  localparam int unsigned RomIdxWidth  = 7;
  localparam int unsigned RomDepth     = 128;
  localparam int unsigned FracBits     = 6;
  localparam int unsigned IntWidth     = 8;
  localparam int unsigned TenthsWidth  = 4;
  localparam int unsigned OutDataWidth = 16;

  localparam logic [IntWidth-1:0]    DbBase      = 8'd21;
  localparam logic [FracBits-1:0]    TenthsRadix = 6'd10;
  localparam logic [RomIdxWidth-1:0] SmallIdx    = 7'd127;

  // Bits 7..6 are the integer part, bits 5..0 the tenths part.
  localparam logic [7:0] DbRom [RomDepth] = '{
    8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,
    8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd6,
    8'd6,   8'd6,   8'd7,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,
    8'd8,   8'd9,   8'd9,   8'd9,   8'd9,   8'd10,  8'd64,  8'd64,
    8'd65,  8'd65,  8'd65,  8'd65,  8'd66,  8'd66,  8'd66,  8'd66,
    8'd67,  8'd67,  8'd67,  8'd67,  8'd68,  8'd68,  8'd68,  8'd68,
    8'd69,  8'd69,  8'd69,  8'd69,  8'd70,  8'd70,  8'd70,  8'd70,
    8'd71,  8'd71,  8'd71,  8'd71,  8'd72,  8'd72,  8'd72,  8'd72,
    8'd72,  8'd73,  8'd73,  8'd73,  8'd73,  8'd74,  8'd74,  8'd74,
    8'd128, 8'd128, 8'd129, 8'd129, 8'd129, 8'd129, 8'd129, 8'd130,
    8'd130, 8'd130, 8'd130, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131,
    8'd132, 8'd132, 8'd132, 8'd132, 8'd132, 8'd133, 8'd133, 8'd133,
    8'd133, 8'd133, 8'd134, 8'd134, 8'd134, 8'd134, 8'd134, 8'd134,
    8'd135, 8'd135, 8'd135, 8'd135, 8'd135, 8'd136, 8'd136, 8'd136,
    8'd136, 8'd136, 8'd136, 8'd137, 8'd137, 8'd137, 8'd137, 8'd137,
    8'd138, 8'd138, 8'd138, 8'd192, 8'd192, 8'd192, 8'd193, 8'd193
  };

  typedef struct packed {
    logic [TenthsWidth-1:0] db_tenths;
    logic [IntWidth-1:0]    db_integer;
  } db_result_t;

endpackage

// ===== sv/dbl_convert.sv =====
// Combinational decibel conversion: leading-one detect, normalize, ROM lookup, add.
// Depends on dbl_pkg for widths, the ROM contents and the result struct.
module dbl_convert
  import dbl_pkg::*;
(
  input  logic [PowerWidth-1:0] power_value,
  output db_result_t            result
);

  logic [MsbWidth-1:0]    msb;
  logic [ShiftWidth-1:0]  shift;
  logic [MantBits-1:0]    mant;
  logic [RomIdxWidth-1:0] idx;
  logic [7:0]             entry;
  logic [IntWidth-1:0]    int_sum;
  logic [FracBits-1:0]    frac_sum;

  // Highest set bit; a zero input reports position zero.
  always_comb begin
    msb = '0;
    for (int i = 0; i < PowerWidth; i++) begin
      if (power_value[i]) begin
        msb = MsbWidth'(i);
      end
    end
  end

  always_comb begin
    if (msb >= MsbWidth'(MantBits)) begin
      shift = ShiftWidth'(msb - MsbWidth'(MantBits - 1));
    end else begin
      shift = '0;
    end
    mant = MantBits'(power_value >> shift);
    // Inputs below 128 have no leading one in the mantissa and use the last entry.
    idx      = mant[MantBits-1] ? mant[RomIdxWidth-1:0] : SmallIdx;
    entry    = DbRom[idx];
    int_sum  = DbBase + IntWidth'(entry[7:FracBits])
             + IntWidth'({2'b00, shift} + {1'b0, shift, 1'b0});
    frac_sum = entry[FracBits-1:0] + FracBits'(shift[ShiftWidth-1:3]);
    if (frac_sum >= TenthsRadix) begin
      result.db_integer = int_sum + 8'd1;
      result.db_tenths  = TenthsWidth'(frac_sum - TenthsRadix);
    end else begin
      result.db_integer = int_sum;
      result.db_tenths  = TenthsWidth'(frac_sum);
    end
  end

endmodule

// ===== sv/decibel_log10_lookup_top.sv =====
// Top level of the decibel log10 lookup block: input register, conversion, output register.
// Depends on dbl_pkg and dbl_convert.
//
// Usage:
// The slave channel (s_tvalid, s_tready, s_tdata) carries one item per power value,
// a 64-bit unsigned linear power in s_tdata. The master channel (m_tvalid, m_tready,
// m_tdata) returns one item per input: db_integer in bits 7..0 and the tenths digit in
// bits 11..8, with bits 15..12 always zero. Together they give 10*log10 of the power
// to one decimal, for example 30.1 dB for a power of 1024.
// An accepted item is captured in the input register, converted by a single pass of
// leading-one detection, a 128-entry constant ROM and small adders, and lands in the
// output register. m_tvalid rises once the item has moved from the input register into
// the output register, where it can be taken. Throughput is one item per cycle while
// the receiver does not stall.
// When the receiver stalls, the output register holds its item and the input register
// keeps a second one; s_tready falls only when both are full, so no item is lost or
// repeated. A synchronous active-high rst empties both registers and drops m_tvalid.
module decibel_log10_lookup_top
  import dbl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [PowerWidth-1:0]   s_tdata,   // [63:0] power_value
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OutDataWidth-1:0] m_tdata    // [7:0] db_integer, [11:8] db_tenths, rest 0
);

  logic                  in_valid;
  logic [PowerWidth-1:0] in_power;
  logic                  out_valid;
  db_result_t            out_result;
  db_result_t            conv_result;
  logic                  out_load;

  dbl_convert u_convert (
    .power_value (in_power),
    .result      (conv_result)
  );

  // The output register takes a new result whenever one is waiting and it is empty or being drained.
  assign out_load = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (out_load) begin
        in_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_power <= s_tdata;
    end
    if (out_load) begin
      out_result <= conv_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OutDataWidth - TenthsWidth - IntWidth){1'b0}},
                     out_result.db_tenths, out_result.db_integer};

endmodule

// ===== sv/dbl_checker.sv =====
// Port-level checker for the decibel log10 lookup block, with its bind statement.
// Depends on dbl_pkg and on the ports of decibel_log10_lookup_top.
module dbl_checker
  import dbl_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    s_tvalid,
  input logic                    s_tready,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [OutDataWidth-1:0] m_tdata
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Tenths digit stays a decimal digit and the pad bits stay zero.
  a_tenths_digit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[11:8] <= 4'd9 && m_tdata[15:12] == 4'd0)
    else $error("tenths digit out of range");

  // Integer part lies between 21 and 193.
  a_int_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:0] >= 8'd21 && m_tdata[7:0] <= 8'd193)
    else $error("integer part out of range");

  // An item accepted while the output is empty reaches it when the receiver does not stall.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid ##1 m_tready |=> m_tvalid)
    else $error("result missing after two cycles");

  // Nothing is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind decibel_log10_lookup_top dbl_checker u_dbl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== verif/decibel_log10_lookup_checker.sv =====
// Checker for the decibel log10 lookup block: watches both stream channels and
// predicts every result from the accepted power values. Depends on dbl_pkg.
`timescale 1ns / 1ps

module decibel_log10_lookup_checker
  import dbl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [PowerWidth-1:0]   s_tdata,   // [63:0] power_value
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  input  logic [OutDataWidth-1:0] m_tdata,   // [7:0] db_integer, [11:8] db_tenths, rest 0
  output int                      mismatches,
  output int                      outstanding
);

  // Integer part in bits 7..6, tenths in bits 5..0, indexed by mantissa minus 128.
  localparam logic [7:0] LEVEL_TABLE [128] = '{
    8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,
    8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd6,
    8'd6,   8'd6,   8'd7,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,
    8'd8,   8'd9,   8'd9,   8'd9,   8'd9,   8'd10,  8'd64,  8'd64,
    8'd65,  8'd65,  8'd65,  8'd65,  8'd66,  8'd66,  8'd66,  8'd66,
    8'd67,  8'd67,  8'd67,  8'd67,  8'd68,  8'd68,  8'd68,  8'd68,
    8'd69,  8'd69,  8'd69,  8'd69,  8'd70,  8'd70,  8'd70,  8'd70,
    8'd71,  8'd71,  8'd71,  8'd71,  8'd72,  8'd72,  8'd72,  8'd72,
    8'd72,  8'd73,  8'd73,  8'd73,  8'd73,  8'd74,  8'd74,  8'd74,
    8'd128, 8'd128, 8'd129, 8'd129, 8'd129, 8'd129, 8'd129, 8'd130,
    8'd130, 8'd130, 8'd130, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131,
    8'd132, 8'd132, 8'd132, 8'd132, 8'd132, 8'd133, 8'd133, 8'd133,
    8'd133, 8'd133, 8'd134, 8'd134, 8'd134, 8'd134, 8'd134, 8'd134,
    8'd135, 8'd135, 8'd135, 8'd135, 8'd135, 8'd136, 8'd136, 8'd136,
    8'd136, 8'd136, 8'd136, 8'd137, 8'd137, 8'd137, 8'd137, 8'd137,
    8'd138, 8'd138, 8'd138, 8'd192, 8'd192, 8'd192, 8'd193, 8'd193
  };
  localparam logic [IntWidth-1:0] BASE_LEVEL = 8'd21;
  localparam logic [5:0]          TEN        = 6'd10;

  db_result_t db_expected_q[$];
  int         result_index = 0;

  initial mismatches = 0;
  initial outstanding = 0;

  // Level of one power value: 3 dB per shift, a tenth per eight shifts,
  // the table for the mantissa, and a carry when the tenths reach ten.
  function automatic db_result_t db_of_power(input logic [PowerWidth-1:0] power);
    logic [5:0]          top_bit;
    logic [5:0]          shift;
    logic [7:0]          mant;
    logic [6:0]          idx;
    logic [7:0]          entry;
    logic [IntWidth-1:0] whole;
    logic [5:0]          tenths;
    db_result_t          res;
    top_bit = '0;
    for (int i = 0; i < PowerWidth; i++) begin
      if (power[i]) top_bit = 6'(i);
    end
    shift = (top_bit >= 6'd8) ? top_bit - 6'd7 : 6'd0;
    mant = 8'(power >> shift);
    // Values under 128 have no leading one in bit 7 and take the last entry.
    idx = mant[7] ? mant[6:0] : 7'd127;
    entry = LEVEL_TABLE[idx];
    whole = BASE_LEVEL + 8'(entry[7:6]) + 8'(shift) * 8'd3;
    tenths = entry[5:0] + 6'(shift >> 3);
    if (tenths >= TEN) begin
      whole = whole + 8'd1;
      tenths = tenths - TEN;
    end
    res.db_integer = whole;
    res.db_tenths = tenths[3:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("ERROR result %0d at %0t: %s is %0d, expected %0d",
             result_index, $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    db_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) db_expected_q.push_back(db_of_power(s_tdata));
      if (m_tvalid && m_tready) begin
        if (db_expected_q.size() == 0) begin
          report_mismatch("unexpected item, m_tdata", int'(m_tdata), 0);
        end else begin
          want = db_expected_q.pop_front();
          if (m_tdata[7:0] !== want.db_integer)
            report_mismatch("db_integer", int'(m_tdata[7:0]), int'(want.db_integer));
          if (m_tdata[11:8] !== want.db_tenths)
            report_mismatch("db_tenths", int'(m_tdata[11:8]), int'(want.db_tenths));
          if (m_tdata[15:12] !== 4'd0)
            report_mismatch("padding", int'(m_tdata[15:12]), 0);
        end
        result_index++;
      end
    end
    outstanding <= db_expected_q.size();
  end

endmodule

// ===== verif/decibel_log10_lookup_top_test.sv =====
// Testbench top for the decibel log10 lookup block: clock, reset, stimulus and verdict.
// Depends on dbl_pkg, decibel_log10_lookup_top and decibel_log10_lookup_checker.
`timescale 1ns / 1ps

module decibel_log10_lookup_top_test
  import dbl_pkg::*;
();

  // A correct run never goes this many cycles without moving an item on
  // either channel; the longest stall is the output hold-off below.
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [PowerWidth-1:0]   s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OutDataWidth-1:0] m_tdata;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;

  // Mode flags shared by the sender and the receiver process.
  bit hold_output = 1'b0;
  bit quiet_tail = 1'b0;

  decibel_log10_lookup_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  decibel_log10_lookup_checker db_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Power value with its leading one at a random position most of the time,
  // so that every shift count and every table entry gets its share. The rest
  // are fully random 64-bit values, which mostly land on the largest shifts.
  function automatic logic [PowerWidth-1:0] random_power();
    logic [PowerWidth-1:0] value;
    int                    top_bit;
    value = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      top_bit = $urandom_range(0, 63);
      value = (value & ((64'd1 << top_bit) - 64'd1)) | (64'd1 << top_bit);
    end
    return value;
  endfunction

  // Offers one item and waits for the edge that takes it. The caller is
  // always at a rising edge, and tvalid is only lowered when a gap follows,
  // so back-to-back items keep it high without a second assignment.
  task automatic offer_power(input logic [PowerWidth-1:0] power, input bit may_idle);
    s_tvalid <= 1'b1;
    s_tdata <= power;
    do @(posedge clk); while (!s_tready);
    if (may_idle && !quiet_tail && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= {$urandom, $urandom};
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Stops offering until every predicted result has come back. The checker
  // registers its count after each acceptance, hence the first wait.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Random phase in chunks of 50 items; some chunks run without sender gaps.
  task automatic random_phase(input int chunks);
    bit gappy;
    for (int c = 0; c < chunks; c++) begin
      gappy = ($urandom_range(0, 2) != 0);
      repeat (50) offer_power(random_power(), gappy);
    end
  endtask

  // Receiver: stretches of ready, random stall bursts, one long hold-off on
  // request, and a steady ready once the tail of the run begins.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_output) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved an item for too long.
  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Directed values: zero and the other small values that read the clamped
  // last entry, the 128 boundary, single powers of two, the full-scale value,
  // alternating bit patterns, and mantissas whose tenths carry into the
  // integer part at small and large shifts.
  logic [PowerWidth-1:0] directed_powers [] = '{
    64'd0, 64'd1, 64'd100, 64'd127, 64'd128, 64'd129, 64'd255, 64'd256,
    64'd1023, 64'd1024,
    64'd157 << 8, 64'd157 << 56, 64'd158 << 56, 64'd255 << 56,
    64'd199 << 40, 64'd200 << 20,
    64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555
  };

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_powers[i]) offer_power(directed_powers[i], 1'b1);

    random_phase(12);

    // The receiver holds off while the sender keeps offering back to back,
    // so both registers fill and the input stalls.
    hold_output = 1'b1;
    repeat (40) offer_power(random_power(), 1'b0);

    // The sender pauses until the block has handed back everything.
    drain_results();

    random_phase(18);

    // Tail of the run with no idling on either side.
    quiet_tail = 1'b1;
    repeat (300) offer_power(random_power(), 1'b0);

    drain_results();
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
